/* hdl/ring_buffer_frame_extractor_defines.svh */
// ----------------------------------------------------------------------------
// Ring buffer frame extractor: assertion macros
// Shorthand for the clocked, reset-qualified properties of the top level.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_FRAME_EXTRACTOR_DEFINES_SVH
`define RING_BUFFER_FRAME_EXTRACTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rbfe_pkg.sv */
// ----------------------------------------------------------------------------
// Ring buffer frame extractor package
// Request/response types, status and request codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbfe_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned FRAME_CAP      = 256;
  localparam int unsigned FRAME_AW       = 8;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;
  localparam logic [7:0] MIN_FRAME  = 8'd6;
  localparam logic [7:0] SUM_FIRST  = 8'd3;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_READ    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NODATA     = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_RESYNC     = 3'd3,
    ST_CHECK      = 3'd4,
    ST_FLUSHED    = 3'd5,
    ST_FULL       = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] offset;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] frame_length;
    logic [7:0] read_byte;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRITE,
    S_FREAD,
    S_FWAIT,
    S_SCAN,
    S_SCAN_CHK,
    S_HDR,
    S_LEN_LO,
    S_LEN_HI,
    S_END_RD,
    S_END_CHK,
    S_SUM_RD,
    S_SUM_ACC,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_COPY_END
  } state_e;

endpackage

/* hdl/ring_buffer_frame_extractor.sv */
// ----------------------------------------------------------------------------
// Ring buffer frame extractor
// Byte ring with a start/length/sum/end deframer and a frame store readback.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o then stays
// high until the result has been produced. An undefined request is the one
// exception: it is answered on the next cycle without raising busy_o. Every
// request yields exactly one result, shown on rsp_o for a single cycle with
// done_o high; the receiver cannot stall it, so capture it on that cycle. A
// byte write passes through S_WRITE, a frame byte read through S_FREAD and
// S_FWAIT. An extract reads one ring byte per byte skipped while hunting for
// the start byte, then checks the header; a good frame adds a checksum pass
// and a copy. Every ring read goes through the single read port of the ring
// RAM, which one byte address unit feeds.
// The ring RAM needs no clearing after reset: only held bytes are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ring_buffer_frame_extractor_defines.svh"

module ring_buffer_frame_extractor #(
  parameter int unsigned RING_DEPTH = rbfe_pkg::RING_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rbfe_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output rbfe_pkg::rsp_t rsp_o
);

  import rbfe_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned HW = PW + 1;
  localparam int unsigned LW = (HW > 17) ? HW : 17;

  state_e        state_q, state_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [7:0]    stored_len_q, stored_len_d;
  logic [7:0]    k_q, k_d;
  logic [7:0]    sum_q, sum_d;
  logic          dir_q, dir_d;
  logic [7:0]    lo_q, lo_d;
  logic [7:0]    len_q, len_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;
  req_t          req_q;

  logic [PW-1:0] au_base;
  logic [7:0]    au_off;
  logic [PW-1:0] au_addr;

  logic          ring_we, ring_re;
  logic [7:0]    ring_rd;
  logic          frame_we, frame_re;
  logic [7:0]    frame_rd;

  logic [HW-1:0] diff;
  logic [PW-1:0] held;
  logic [15:0]   len16;

  rbfe_addr_unit #(
    .RING_DEPTH(RING_DEPTH),
    .PW        (PW)
  ) u_addr_unit (
    .base_i(au_base),
    .off_i (au_off),
    .addr_o(au_addr)
  );

  rbfe_ram #(
    .DEPTH(RING_DEPTH),
    .AW   (PW)
  ) u_ring_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ring_we),
    .wr_addr_i(wp_q),
    .wr_data_i(req_q.data_byte),
    .rd_en_i  (ring_re),
    .rd_addr_i(au_addr),
    .rd_data_o(ring_rd)
  );

  rbfe_ram #(
    .DEPTH(FRAME_CAP),
    .AW   (FRAME_AW)
  ) u_frame_ram (
    .clk_i    (clk_i),
    .wr_en_i  (frame_we),
    .wr_addr_i(k_q),
    .wr_data_i(ring_rd),
    .rd_en_i  (frame_re),
    .rd_addr_i(req_q.offset),
    .rd_data_o(frame_rd)
  );

  // Bytes held in the ring, wrapped at the depth.
  always_comb begin
    diff = HW'(wp_q) - HW'(rp_q);
    if (wp_q < rp_q) begin
      diff = diff + HW'(RING_DEPTH);
    end
    held = PW'(diff);
  end

  assign len16 = {ring_rd, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rp_q         <= '0;
      wp_q         <= '0;
      stored_len_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      rp_q         <= rp_d;
      wp_q         <= wp_d;
      stored_len_q <= stored_len_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    sum_q <= sum_d;
    dir_q <= dir_d;
    lo_q  <= lo_d;
    len_q <= len_d;
    rsp_q <= rsp_d;
    if (start_i && (state_q == S_IDLE)) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    stored_len_d = stored_len_q;
    k_d          = k_q;
    sum_d        = sum_q;
    dir_d        = dir_q;
    lo_d         = lo_q;
    len_d        = len_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    au_base      = rp_q;
    au_off       = 8'd0;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    frame_we     = 1'b0;
    frame_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.kind)
            KIND_WRITE:   state_d = S_WRITE;
            KIND_EXTRACT: state_d = S_SCAN;
            KIND_READ:    state_d = S_FREAD;
            default: begin
              done_d             = 1'b1;
              rsp_d.status       = ST_OK;
              rsp_d.frame_length = 8'd0;
              rsp_d.read_byte    = 8'd0;
            end
          endcase
        end
      end

      S_WRITE: begin
        au_base            = wp_q;
        au_off             = 8'd1;
        done_d             = 1'b1;
        rsp_d.frame_length = 8'd0;
        rsp_d.read_byte    = 8'd0;
        state_d            = S_IDLE;
        if (au_addr == rp_q) begin
          rsp_d.status = ST_FULL;
        end else begin
          ring_we      = 1'b1;
          wp_d         = au_addr;
          rsp_d.status = ST_OK;
        end
      end

      S_FREAD: begin
        frame_re = 1'b1;
        state_d  = S_FWAIT;
      end

      S_FWAIT: begin
        done_d             = 1'b1;
        rsp_d.status       = ST_OK;
        rsp_d.frame_length = 8'd0;
        rsp_d.read_byte    = (req_q.offset < stored_len_q) ? frame_rd : 8'd0;
        state_d            = S_IDLE;
      end

      S_SCAN: begin
        if (rp_q == wp_q) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_NODATA, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d = S_IDLE;
        end else begin
          ring_re = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        // Drop anything ahead of the start byte.
        if (ring_rd != START_BYTE) begin
          au_off  = 8'd1;
          rp_d    = au_addr;
          state_d = S_SCAN;
        end else begin
          state_d = S_HDR;
        end
      end

      S_HDR: begin
        if (LW'(held) < LW'(MIN_FRAME)) begin
          done_d       = 1'b1;
          rsp_d        = '{status: ST_INCOMPLETE, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d      = S_IDLE;
        end else begin
          au_off  = 8'd1;
          ring_re = 1'b1;
          state_d = S_LEN_LO;
        end
      end

      S_LEN_LO: begin
        lo_d    = ring_rd;
        au_off  = 8'd2;
        ring_re = 1'b1;
        state_d = S_LEN_HI;
      end

      S_LEN_HI: begin
        len_d = len16[7:0];
        priority if ((LW'(len16) > LW'(RING_DEPTH)) || (len16[15:8] != 8'd0)) begin
          rp_d         = wp_q;
          done_d       = 1'b1;
          rsp_d        = '{status: ST_FLUSHED, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d      = S_IDLE;
        end else if (LW'(len16) > LW'(held)) begin
          done_d       = 1'b1;
          rsp_d        = '{status: ST_INCOMPLETE, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d      = S_IDLE;
        end else if (len16[7:0] < MIN_FRAME) begin
          au_off       = 8'd1;
          rp_d         = au_addr;
          done_d       = 1'b1;
          rsp_d        = '{status: ST_RESYNC, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d      = S_IDLE;
        end else begin
          state_d = S_END_RD;
        end
      end

      S_END_RD: begin
        au_off  = len_q - 8'd1;
        ring_re = 1'b1;
        state_d = S_END_CHK;
      end

      S_END_CHK: begin
        if (ring_rd != END_BYTE) begin
          au_off       = 8'd1;
          rp_d         = au_addr;
          done_d       = 1'b1;
          rsp_d        = '{status: ST_RESYNC, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d      = S_IDLE;
        end else begin
          k_d     = SUM_FIRST;
          sum_d   = 8'd0;
          dir_d   = 1'b0;
          state_d = S_SUM_RD;
        end
      end

      S_SUM_RD: begin
        au_off  = k_q;
        ring_re = 1'b1;
        state_d = S_SUM_ACC;
      end

      S_SUM_ACC: begin
        sum_d = sum_q + ring_rd;
        if (k_q == SUM_FIRST) begin
          dir_d = ring_rd[7];
        end
        if (k_q == len_q - 8'd3) begin
          state_d = S_TAIL_RD;
        end else begin
          k_d     = k_q + 8'd1;
          state_d = S_SUM_RD;
        end
      end

      S_TAIL_RD: begin
        au_off  = len_q - 8'd2;
        ring_re = 1'b1;
        state_d = S_TAIL_CHK;
      end

      S_TAIL_CHK: begin
        // Skip the whole frame on a bad sum or an upstream direction bit.
        if ((ring_rd != sum_q) || dir_q) begin
          au_off       = len_q;
          rp_d         = au_addr;
          done_d       = 1'b1;
          rsp_d        = '{status: ST_CHECK, frame_length: 8'd0, read_byte: 8'd0};
          stored_len_d = 8'd0;
          state_d      = S_IDLE;
        end else begin
          k_d     = 8'd0;
          state_d = S_COPY_RD;
        end
      end

      S_COPY_RD: begin
        au_off  = k_q;
        ring_re = 1'b1;
        state_d = S_COPY_WR;
      end

      S_COPY_WR: begin
        frame_we = 1'b1;
        if (k_q == len_q - 8'd1) begin
          state_d = S_COPY_END;
        end else begin
          k_d     = k_q + 8'd1;
          state_d = S_COPY_RD;
        end
      end

      S_COPY_END: begin
        au_off       = len_q;
        rp_d         = au_addr;
        stored_len_d = len_q;
        done_d       = 1'b1;
        rsp_d        = '{status: ST_OK, frame_length: len_q, read_byte: 8'd0};
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `RBFE_ASSERT_NOW(a_done_idle, done_o, !busy_o, "result strobe while the sequencer is busy")
  `RBFE_ASSERT_NEXT(a_accept_busy, start_i && !busy_o && (req_i.kind <= KIND_READ), busy_o,
                    "accepted request did not start the sequencer")
  `RBFE_ASSERT_NOW(a_len_only_ok, done_o && (rsp_o.status != ST_OK), rsp_o.frame_length == 8'd0,
                   "frame length reported on a failed request")
  `RBFE_ASSERT_NOW(a_len_min, done_o && (rsp_o.frame_length != 8'd0),
                   rsp_o.frame_length >= MIN_FRAME, "extracted frame shorter than minimum")

endmodule

/* hdl/rbfe_ram.sv */
// ----------------------------------------------------------------------------
// Byte RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbfe_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/rbfe_addr_unit.sv */
// ----------------------------------------------------------------------------
// Ring address unit
// Shared adder: base pointer plus byte offset, wrapped at the ring depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbfe_addr_unit #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned PW         = 8
) (
  input  logic [PW-1:0] base_i,
  input  logic [7:0]    off_i,
  output logic [PW-1:0] addr_o
);

  localparam int unsigned SW = ((PW > 8) ? PW : 8) + 1;

  logic [SW-1:0] sum;

  // Offsets never reach twice the depth, so one conditional subtract wraps.
  always_comb begin
    sum = SW'(base_i) + SW'(off_i);
    if (sum >= SW'(RING_DEPTH)) begin
      addr_o = PW'(sum - SW'(RING_DEPTH));
    end else begin
      addr_o = PW'(sum);
    end
  end

endmodule

/* tb/tb_ring_buffer_frame_extractor.sv */
// ----------------------------------------------------------------------------
// Ring buffer frame extractor testbench
// Drives byte writes, extract requests and frame reads through the start/busy
// handshake, predicts every response from a cycle-free model of the ring and
// frame store, and checks each done_o response field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ring_buffer_frame_extractor;
  import rbfe_pkg::*;

  localparam int         ITEMS      = 1100;
  localparam logic [1:0] KIND_UNDEF = 2'd3;

  typedef enum int {
    FR_GOOD,
    FR_BAD_END,
    FR_BAD_SUM,
    FR_DIR,
    FR_SHORT_LEN,
    FR_HUGE_LEN
  } frame_kind_e;

  // Tracks ring and frame store contents, predicts responses, checks them.
  class deframer_tracker;
    bit [7:0] ring [256];
    bit [7:0] frame_buf [256];
    bit [7:0] rd_ptr;
    bit [7:0] wr_ptr;
    bit [7:0] frame_len;
    rsp_t     rsp_due [$];
    int       errors;

    function new();
      rd_ptr    = '0;
      wr_ptr    = '0;
      frame_len = '0;
      errors    = 0;
    endfunction

    function bit [7:0] held();
      return 8'(wr_ptr - rd_ptr);
    endfunction

    function bit [7:0] ring_at(int k);
      return ring[8'(rd_ptr + k)];
    endfunction

    function rsp_t extract_frame();
      rsp_t     r;
      int       avail;
      int       len;
      bit [7:0] sum;
      r = '0;
      // drop everything ahead of the next start byte
      while (rd_ptr != wr_ptr && ring[rd_ptr] != START_BYTE) rd_ptr = 8'(rd_ptr + 1);
      if (rd_ptr == wr_ptr) begin
        r.status = ST_NODATA;
        return r;
      end
      avail = int'(held());
      if (avail < int'(MIN_FRAME)) begin
        r.status = ST_INCOMPLETE;
        return r;
      end
      len = {ring_at(2), ring_at(1)};
      if (len > int'(RING_DEPTH_DEF) || len > int'(FRAME_CAP) - 1) begin
        rd_ptr   = wr_ptr;
        r.status = ST_FLUSHED;
        return r;
      end
      if (len > avail) begin
        r.status = ST_INCOMPLETE;
        return r;
      end
      if (len < int'(MIN_FRAME) || ring_at(len - 1) != END_BYTE) begin
        rd_ptr   = 8'(rd_ptr + 1);
        r.status = ST_RESYNC;
        return r;
      end
      sum = '0;
      for (int k = int'(SUM_FIRST); k <= len - 3; k++) sum = 8'(sum + ring_at(k));
      if (sum != ring_at(len - 2) || (ring_at(3) & 8'h80) != 8'h00) begin
        rd_ptr   = 8'(rd_ptr + len);
        r.status = ST_CHECK;
        return r;
      end
      for (int k = 0; k < len; k++) frame_buf[k] = ring_at(k);
      rd_ptr         = 8'(rd_ptr + len);
      frame_len      = 8'(len);
      r.status       = ST_OK;
      r.frame_length = 8'(len);
      return r;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      want = '0;
      case (r.kind)
        KIND_WRITE: begin
          if (8'(wr_ptr + 1) == rd_ptr) begin
            want.status = ST_FULL;
          end else begin
            ring[wr_ptr] = r.data_byte;
            wr_ptr       = 8'(wr_ptr + 1);
          end
        end
        KIND_EXTRACT: begin
          want = extract_frame();
          if (want.status != ST_OK) frame_len = '0;
        end
        KIND_READ: begin
          if (r.offset < frame_len) want.read_byte = frame_buf[r.offset];
        end
        default: ;
      endcase
      rsp_due.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (rsp_due.size() == 0) begin
        $error("unexpected response: status %0d frame_length %0d read_byte %0d",
               got.status, got.frame_length, got.read_byte);
        errors++;
        return;
      end
      want = rsp_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        errors++;
      end
      if (got.read_byte !== want.read_byte) begin
        $error("read_byte: expected 0x%02h, got 0x%02h", want.read_byte, got.read_byte);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  deframer_tracker tracker;
  bit [7:0]        frame_bytes [$];
  int              sent;
  int              idle_pct;

  ring_buffer_frame_extractor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) tracker.check_response(rsp_o);
  end

  function automatic bit [7:0] rand_byte();
    return 8'($urandom());
  endfunction

  // Hold off a random burst, then present the request until it is taken.
  task automatic issue(bit [1:0] kind, bit [7:0] data, bit [7:0] off);
    req_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.offset    = off;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    tracker.note_request(r);
    if (kind != KIND_UNDEF) sent++;
  endtask

  task automatic issue_write(bit [7:0] b);
    issue(KIND_WRITE, b, rand_byte());
  endtask

  task automatic issue_extract();
    issue(KIND_EXTRACT, rand_byte(), rand_byte());
  endtask

  task automatic issue_read(bit [7:0] off);
    issue(KIND_READ, rand_byte(), off);
  endtask

  function automatic void build_frame(frame_kind_e fk, int len);
    bit [7:0] sum;
    bit [7:0] b;
    frame_bytes.delete();
    if (fk == FR_SHORT_LEN || fk == FR_HUGE_LEN) begin
      if (fk == FR_SHORT_LEN) len = $urandom_range(0, 5);
      else if ($urandom_range(0, 2) == 0) len = 256;
      else len = $urandom_range(257, 65535);
      frame_bytes.push_back(START_BYTE);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(len[15:8]);
      repeat ($urandom_range(3, 8)) frame_bytes.push_back(rand_byte());
      return;
    end
    frame_bytes.push_back(START_BYTE);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    b = rand_byte();
    b[7] = (fk == FR_DIR);
    frame_bytes.push_back(b);
    for (int k = 4; k <= len - 3; k++) frame_bytes.push_back(rand_byte());
    sum = '0;
    for (int k = 3; k <= len - 3; k++) sum = 8'(sum + frame_bytes[k]);
    if (fk == FR_BAD_SUM) sum = 8'(sum + $urandom_range(1, 255));
    frame_bytes.push_back(sum);
    b = rand_byte();
    if (fk != FR_BAD_END) b = END_BYTE;
    else if (b == END_BYTE) b = ~b;
    frame_bytes.push_back(b);
  endfunction

  task automatic send_frame(frame_kind_e fk, int len, bit noise_ok);
    int cut;
    build_frame(fk, len);
    if (noise_ok && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) issue_write(rand_byte());
    // sometimes ask for the frame before all of it has arrived
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_bytes.size() - 1)
                                      : frame_bytes.size();
    foreach (frame_bytes[i]) begin
      if (i == cut) issue_extract();
      issue_write(frame_bytes[i]);
    end
    issue_extract();
    if (fk != FR_GOOD && $urandom_range(0, 1) == 0) issue_extract();
    repeat ($urandom_range(0, 3))
      issue_read($urandom_range(0, 1) ? 8'($urandom_range(0, int'(tracker.frame_len)))
                                      : rand_byte());
  endtask

  task automatic send_random_frame();
    int          v;
    frame_kind_e fk;
    v = $urandom_range(0, 99);
    if (v < 45) fk = FR_GOOD;
    else if (v < 55) fk = FR_BAD_END;
    else if (v < 65) fk = FR_BAD_SUM;
    else if (v < 75) fk = FR_DIR;
    else if (v < 87) fk = FR_SHORT_LEN;
    else fk = FR_HUGE_LEN;
    send_frame(fk, $urandom_range(6, 40), 1'b1);
  endtask

  // Stack frames without extracting until the ring overflows, then drain.
  task automatic fill_ring();
    while (tracker.held() < 8'd230) begin
      build_frame(FR_GOOD, $urandom_range(8, 30));
      foreach (frame_bytes[i]) issue_write(frame_bytes[i]);
    end
    repeat (30) issue_write(rand_byte());
    repeat (24) begin
      issue_extract();
      if ($urandom_range(0, 2) == 0) issue_read(rand_byte());
    end
  endtask

  task automatic long_frame(int len);
    int tries;
    tries = 0;
    while (tracker.held() != 0 && tries < 12) begin
      // an oversized length field flushes whatever is stuck at the head
      if (tries >= 4) begin
        issue_write(START_BYTE);
        issue_write(8'hFF);
        issue_write(8'hFF);
        repeat (3) issue_write(rand_byte());
      end
      issue_extract();
      tries++;
    end
    send_frame(FR_GOOD, len, 1'b0);
  endtask

  initial begin
    int pick;
    int fills;
    int longs;
    tracker  = new();
    sent     = 0;
    idle_pct = 0;
    fills    = 0;
    longs    = 0;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    req_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: undefined kind, reads before any frame, empty and noise-only
    // extracts, a short-then-complete minimum frame, reads in and past it
    issue(KIND_UNDEF, 8'hFF, 8'hFF);
    issue_read(8'h00);
    issue_extract();
    issue_write(8'h00);
    issue_write(8'hFF);
    issue_extract();
    issue_write(START_BYTE);
    issue_write(MIN_FRAME);
    issue_write(8'h00);
    issue_extract();
    issue_write(8'h7F);
    issue_write(8'h7F);
    issue_write(END_BYTE);
    issue_extract();
    issue_read(8'h00);
    issue_read(8'h05);
    issue_read(8'h06);
    issue_read(8'hFF);
    issue_extract();
    issue_read(8'h00);

    while (sent < ITEMS) begin
      if (sent >= ITEMS - 150) idle_pct = 0;
      else if ($urandom_range(0, 3) == 0) idle_pct = 0;
      else idle_pct = $urandom_range(10, 60);
      pick = $urandom_range(0, 99);
      if ((fills == 0 && sent > 300) || (fills == 1 && sent > 700)) begin
        fill_ring();
        fills++;
      end else if (longs == 0 && sent > 450) begin
        long_frame(255);
        longs++;
      end else if (longs == 1 && sent > 850) begin
        long_frame($urandom_range(200, 254));
        longs++;
      end else if (pick < 60) begin
        send_random_frame();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 8)) issue_write(rand_byte());
        issue_extract();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) issue_read(rand_byte());
      end else if (pick < 95) begin
        issue(KIND_UNDEF, rand_byte(), rand_byte());
      end else begin
        issue_extract();
      end
    end
    start_i <= 1'b0;

    while (tracker.rsp_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.rsp_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/rbfe_pkg.sv
hdl/rbfe_ram.sv
hdl/rbfe_addr_unit.sv
hdl/ring_buffer_frame_extractor.sv
tb/tb_ring_buffer_frame_extractor.sv
